[rtl/hmlb_pkg.sv]
// Shared definitions for the hash modulo load balancer core.
// Command and status codes and fixed field widths; no dependencies.
`default_nettype none
package hmlb_pkg;

    localparam int SEL_W  = 10;
    localparam int MAP_W  = 16;
    localparam int CNT64_W = 64;

    localparam logic [2:0] CMD_PKT   = 3'd0;
    localparam logic [2:0] CMD_ADD   = 3'd1;
    localparam logic [2:0] CMD_ACT   = 3'd2;
    localparam logic [2:0] CMD_DEACT = 3'd3;
    localparam logic [2:0] CMD_CHG   = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_CONN  = 3'd1;
    localparam logic [2:0] ST_LIST_FULL = 3'd2;
    localparam logic [2:0] ST_ACTIVE    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic [CNT64_W-1:0] FRAME_EXTRA_BYTES = 64'd24;

endpackage
`default_nettype wire

[rtl/hmlb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module hmlb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/hash_modulo_load_balancer_core.sv]
// Flow load balancer: packet gate selection by hash modulo active count,
// gate table commands and byte counters. Uses hmlb_pkg and hmlb_ram.
//
// One transaction at a time. A packet with a parsed flow passes through a
// decode state, a 32-step restoring remainder unit, list read, mapping and
// counter read, counter write and output. An unparsed packet skips the
// remainder unit; a dropped packet goes from decode straight to output.
// Activate and deactivate walk the active list through its single read port.
// Add, change and errors go from decode straight to output; read passes
// through a counter read first. The block returns to idle after output before
// the next transaction is accepted, and a stalled result holds the block in
// its output state. Tables need no clearing pass after reset; a new gate's counter is zeroed when added.
`default_nettype none
module hash_modulo_load_balancer_core #(
    parameter int MAX_GATE_COUNT = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_cmd,
    input  wire logic        i_flow_ok,
    input  wire logic [31:0] i_flow_hash,
    input  wire logic [15:0] i_pkt_len,
    input  wire logic [9:0]  i_gate_sel,
    input  wire logic [15:0] i_fwd_map,
    input  wire logic [15:0] i_rev_map,
    input  wire logic        i_make_active,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [9:0]       o_out_gate,
    output logic [15:0]      o_fwd_value,
    output logic [15:0]      o_rev_value,
    output logic             o_dropped,
    output logic [2:0]       o_status,
    output logic [63:0]      o_result_value
);

    localparam int IDX_W = $clog2(MAX_GATE_COUNT);
    localparam int CNT_W = $clog2(MAX_GATE_COUNT + 1);
    localparam int CMP_W = (CNT_W > hmlb_pkg::SEL_W) ? CNT_W : hmlb_pkg::SEL_W;
    localparam int MAPW2 = 2 * hmlb_pkg::MAP_W;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_EXEC = 11'b00000000010,
        S_DIV  = 11'b00000000100,
        S_LRD  = 11'b00000001000,
        S_LWT  = 11'b00000010000,
        S_ACC  = 11'b00000100000,
        S_SCAN = 11'b00001000000,
        S_SFIN = 11'b00010000000,
        S_CRD  = 11'b00100000000,
        S_CWT  = 11'b01000000000,
        S_OUT  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_conn, n_conn, r_act, n_act;
    logic [2:0]  r_cmd;
    logic        r_flow_ok, r_make_active;
    logic [31:0] r_flow_hash_q;
    logic [15:0] r_pkt_len, r_fwd_map, r_rev_map;
    logic [9:0]  r_gate_sel;
    logic [31:0] r_dvd, n_dvd;
    logic [CNT_W:0] r_rem, n_rem;
    logic [4:0]  r_step, n_step;
    logic [CNT_W-1:0] r_idx, n_idx, r_wj, n_wj;
    logic        r_pv, n_pv, r_found, n_found;
    logic [IDX_W-1:0] r_gate, n_gate;
    logic [15:0] r_fwd, n_fwd, r_rev, n_rev;
    logic        r_drop, n_drop;
    logic [2:0]  r_status, n_status;
    logic [63:0] r_result, n_result;
    logic        r_ovalid, n_ovalid;

    logic al_we, mp_we, ct_we;
    logic [IDX_W-1:0] al_waddr, al_raddr, mp_waddr, ct_waddr, mc_raddr;
    logic [IDX_W-1:0] al_wdata, al_rdata;
    logic [MAPW2-1:0] mp_wdata, mp_rdata;
    logic [63:0] ct_wdata, ct_rdata;

    logic [IDX_W-1:0] sel_idx, gate_now;
    logic [CMP_W-1:0] sel_cmp;
    logic sel_bad;
    logic [CNT_W:0] div_t;

    hmlb_ram #(.WIDTH(IDX_W), .DEPTH(MAX_GATE_COUNT)) u_alist (
        .i_clk(i_clk), .i_we(al_we), .i_waddr(al_waddr), .i_wdata(al_wdata),
        .i_raddr(al_raddr), .o_rdata(al_rdata)
    );
    hmlb_ram #(.WIDTH(MAPW2), .DEPTH(MAX_GATE_COUNT)) u_map (
        .i_clk(i_clk), .i_we(mp_we), .i_waddr(mp_waddr), .i_wdata(mp_wdata),
        .i_raddr(mc_raddr), .o_rdata(mp_rdata)
    );
    hmlb_ram #(.WIDTH(64), .DEPTH(MAX_GATE_COUNT)) u_cnt (
        .i_clk(i_clk), .i_we(ct_we), .i_waddr(ct_waddr), .i_wdata(ct_wdata),
        .i_raddr(mc_raddr), .o_rdata(ct_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign sel_idx  = IDX_W'(r_gate_sel);
    assign sel_cmp  = CMP_W'(r_gate_sel);
    assign sel_bad  = sel_cmp >= CMP_W'(r_conn);
    assign gate_now = r_flow_ok ? al_rdata : '0;
    assign div_t    = {r_rem[CNT_W-1:0], r_dvd[31]};
    assign mc_raddr = (r_state == S_CRD) ? sel_idx : gate_now;
    assign al_raddr = (r_state == S_LRD) ? IDX_W'(r_rem) : r_idx[IDX_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_conn   = r_conn;
        n_act    = r_act;
        n_dvd    = r_dvd;
        n_rem    = r_rem;
        n_step   = r_step;
        n_idx    = r_idx;
        n_wj     = r_wj;
        n_pv     = r_pv;
        n_found  = r_found;
        n_gate   = r_gate;
        n_fwd    = r_fwd;
        n_rev    = r_rev;
        n_drop   = r_drop;
        n_status = r_status;
        n_result = r_result;
        n_ovalid = r_ovalid & i_out_stall;
        al_we    = 1'b0;
        al_waddr = r_wj[IDX_W-1:0];
        al_wdata = al_rdata;
        mp_we    = 1'b0;
        mp_waddr = sel_idx;
        mp_wdata = {r_fwd_map, r_rev_map};
        ct_we    = 1'b0;
        ct_waddr = r_gate;
        ct_wdata = ct_rdata + 64'(r_pkt_len) + hmlb_pkg::FRAME_EXTRA_BYTES;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_gate   = '0;
                n_fwd    = '0;
                n_rev    = '0;
                n_drop   = 1'b0;
                n_status = hmlb_pkg::ST_OK;
                n_result = '0;
                n_state  = S_OUT;
                n_idx    = '0;
                n_wj     = '0;
                n_pv     = 1'b0;
                n_found  = 1'b0;
                case (r_cmd)
                    hmlb_pkg::CMD_PKT: begin
                        if (r_act == '0) begin
                            n_drop = 1'b1;
                        end else if (r_flow_ok) begin
                            n_dvd   = r_flow_hash_q;
                            n_rem   = '0;
                            n_step  = '0;
                            n_state = S_DIV;
                        end else begin
                            n_state = S_LRD;
                        end
                    end
                    hmlb_pkg::CMD_ADD: begin
                        if (r_conn >= CNT_W'(MAX_GATE_COUNT)) begin
                            n_status = hmlb_pkg::ST_NOT_CONN;
                        end else if (r_make_active && r_act >= CNT_W'(MAX_GATE_COUNT)) begin
                            n_status = hmlb_pkg::ST_LIST_FULL;
                        end else begin
                            mp_we    = 1'b1;
                            mp_waddr = r_conn[IDX_W-1:0];
                            ct_we    = 1'b1;
                            ct_waddr = r_conn[IDX_W-1:0];
                            ct_wdata = '0;
                            if (r_make_active) begin
                                al_we    = 1'b1;
                                al_waddr = r_act[IDX_W-1:0];
                                al_wdata = r_conn[IDX_W-1:0];
                                n_act    = r_act + 1'b1;
                            end
                            n_result = 64'(r_conn);
                            n_conn   = r_conn + 1'b1;
                        end
                    end
                    hmlb_pkg::CMD_ACT: begin
                        if (sel_bad) begin
                            n_status = hmlb_pkg::ST_NOT_CONN;
                        end else if (r_act >= CNT_W'(MAX_GATE_COUNT)) begin
                            n_status = hmlb_pkg::ST_LIST_FULL;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    hmlb_pkg::CMD_DEACT: begin
                        if (sel_bad) begin
                            n_status = hmlb_pkg::ST_NOT_CONN;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    hmlb_pkg::CMD_CHG: begin
                        if (sel_bad) begin
                            n_status = hmlb_pkg::ST_NOT_CONN;
                        end else begin
                            mp_we = 1'b1;
                        end
                    end
                    hmlb_pkg::CMD_READ: begin
                        if (sel_cmp >= CMP_W'(MAX_GATE_COUNT)) begin
                            n_status = hmlb_pkg::ST_NOT_FOUND;
                        end else if (!sel_bad) begin
                            n_state = S_CRD;
                        end
                    end
                    default: begin
                        n_status = hmlb_pkg::ST_NOT_CONN;
                    end
                endcase
            end
            S_DIV: begin
                if (div_t >= {1'b0, r_act}) begin
                    n_rem = div_t - {1'b0, r_act};
                end else begin
                    n_rem = div_t;
                end
                n_dvd  = {r_dvd[30:0], 1'b0};
                n_step = r_step + 1'b1;
                if (r_step == 5'd31) begin
                    n_state = S_LRD;
                end
            end
            S_LRD: begin
                n_state = S_LWT;
            end
            S_LWT: begin
                n_gate  = gate_now;
                n_state = S_ACC;
            end
            S_ACC: begin
                ct_we   = 1'b1;
                n_fwd   = mp_rdata[MAPW2-1:hmlb_pkg::MAP_W];
                n_rev   = mp_rdata[hmlb_pkg::MAP_W-1:0];
                n_state = S_OUT;
            end
            S_SCAN: begin
                n_pv = 1'b0;
                if (r_pv) begin
                    if (al_rdata == sel_idx) begin
                        n_found = 1'b1;
                    end else if (r_cmd == hmlb_pkg::CMD_DEACT) begin
                        al_we = 1'b1;
                        n_wj  = r_wj + 1'b1;
                    end
                end
                if (r_idx < r_act) begin
                    n_idx = r_idx + 1'b1;
                    n_pv  = 1'b1;
                end else if (!r_pv) begin
                    n_state = S_SFIN;
                end
            end
            S_SFIN: begin
                n_state = S_OUT;
                if (r_cmd == hmlb_pkg::CMD_ACT) begin
                    if (r_found) begin
                        n_status = hmlb_pkg::ST_ACTIVE;
                    end else begin
                        al_we    = 1'b1;
                        al_waddr = r_act[IDX_W-1:0];
                        al_wdata = sel_idx;
                        n_act    = r_act + 1'b1;
                    end
                end else if (r_found) begin
                    n_act = r_wj;
                end else begin
                    n_status = hmlb_pkg::ST_NOT_FOUND;
                end
            end
            S_CRD: begin
                n_state = S_CWT;
            end
            S_CWT: begin
                n_result = ct_rdata;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_conn   <= '0;
            r_act    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_conn   <= n_conn;
            r_act    <= n_act;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_cmd         <= i_cmd;
            r_flow_ok     <= i_flow_ok;
            r_flow_hash_q <= i_flow_hash;
            r_pkt_len     <= i_pkt_len;
            r_gate_sel    <= i_gate_sel;
            r_fwd_map     <= i_fwd_map;
            r_rev_map     <= i_rev_map;
            r_make_active <= i_make_active;
        end
        r_dvd    <= n_dvd;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_idx    <= n_idx;
        r_wj     <= n_wj;
        r_pv     <= n_pv;
        r_found  <= n_found;
        r_gate   <= n_gate;
        r_fwd    <= n_fwd;
        r_rev    <= n_rev;
        r_drop   <= n_drop;
        r_status <= n_status;
        r_result <= n_result;
        if (r_state == S_OUT && (!r_ovalid || !i_out_stall)) begin
            o_out_gate     <= 10'(r_gate);
            o_fwd_value    <= r_fwd;
            o_rev_value    <= r_rev;
            o_dropped      <= r_drop;
            o_status       <= r_status;
            o_result_value <= r_result;
        end
    end

    assign o_out_valid = r_ovalid;

    a_act_le_conn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act <= r_conn)
        else $error("active count exceeds connected count");

    a_conn_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_conn <= CNT_W'(MAX_GATE_COUNT))
        else $error("connected count beyond table size");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_act != '0))
        else $error("remainder unit started with zero divisor");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_step == 5'd31) |=> (r_rem < {1'b0, r_act}))
        else $error("remainder not below active count");

endmodule
`default_nettype wire
